[src/blm_pkg.sv]
// Shared types and constants of the battery level monitor.
// Used by the serial multiplier, the serial divider and the top level.
`timescale 1ns / 1ps

package blm_pkg;

	// Field and register widths
	localparam int SENSE_W = 12;
	localparam int MV_W    = 16;
	localparam int RES_W   = 20;
	localparam int TOTAL_W = RES_W + 1;
	localparam int PROD_W  = SENSE_W + TOTAL_W;
	localparam int NUM_W   = PROD_W + 1;
	localparam int IDX_W   = 3;
	localparam int LEVEL_W = 2;

	// Stream widths, padded to whole bytes
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 40;

	// Default number of readings per average
	localparam int SAMPLES_DEF = 16;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_DIV_TOP   = 3'd0;
	localparam logic [IDX_W-1:0] REG_DIV_BOT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CRIT_ENT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_CRIT_LEAVE = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOW_ENT   = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOW_LEAVE = 3'd5;

	// Register reset values
	localparam logic [RES_W-1:0] DIV_TOP_RST    = 20'd20000;
	localparam logic [RES_W-1:0] DIV_BOT_RST    = 20'd10000;
	localparam logic [MV_W-1:0]  CRIT_ENT_RST   = 16'd6400;
	localparam logic [MV_W-1:0]  CRIT_LEAVE_RST = 16'd6800;
	localparam logic [MV_W-1:0]  LOW_ENT_RST    = 16'd7000;
	localparam logic [MV_W-1:0]  LOW_LEAVE_RST  = 16'd7300;

	// Battery level codes
	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_OK   = 2'd0,
		LEVEL_LOW  = 2'd1,
		LEVEL_CRIT = 2'd2
	} level_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [RES_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	// Multiplier request and response
	typedef struct packed {
		logic               start;
		logic [SENSE_W-1:0] a;
		logic [TOTAL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage

[src/blm_serial_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on blm_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module blm_serial_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  blm_pkg::mul_req_t  req,
	output blm_pkg::mul_rsp_t  rsp
);

	localparam int AW = blm_pkg::SENSE_W;
	localparam int BW = blm_pkg::TOTAL_W;
	localparam int PW = blm_pkg::PROD_W;
	localparam int CW = $clog2(AW + 1);

	logic [PW-1:0] acc_q;
	logic [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] acc_nxt;

	// Shift the partial product and add the multiplicand on a set bit
	assign acc_nxt = {acc_q[PW-2:0], 1'b0} + (a_q[AW-1] ? PW'(b_q) : '0);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(AW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and accumulator shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			a_q   <= {a_q[AW-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

[src/blm_serial_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on blm_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module blm_serial_div (
	input  logic               clk,
	input  logic               arst_n,
	input  blm_pkg::div_req_t  req,
	output blm_pkg::div_rsp_t  rsp
);

	localparam int NW = blm_pkg::NUM_W;
	localparam int DW = blm_pkg::RES_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          ge;

	// Bring down the next numerator bit and trial-subtract the divisor
	assign rem_sh  = {rem_q, quot_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Numerator bits shift out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.numer;
			rem_q  <= '0;
			den_q  <= req.denom;
		end else if (busy_q) begin
			quot_q <= {quot_q[NW-2:0], ge};
			rem_q  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

[src/battery_level_monitor_unit.sv]
// Battery level monitor top level: sample accumulation, sequencer, filter,
// level classification and output register. Depends on blm_pkg,
// blm_serial_mul and blm_serial_div.
`timescale 1ns / 1ps
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata[11:0] sense_mv
//  m_*      out  m_tvalid / m_tready  measured, filtered, level, changed
//  cfg_*    in   cfg_we               cfg_index selects, cfg_wdata[19:0]
//
//  A reading is accepted whenever s_tvalid and s_tready are both high. The
//  last reading of a group starts a pass made of two runs of the shared
//  bit-serial divider (average, then divider scaling) and the 12-step
//  serial multiplier; s_tready is low during that pass, and the result
//  reaches m_tvalid at its end when the output register is free.
//  A result waits in the output register while readings keep coming; the
//  next result holds in the sequencer until that register is free.
//  Reset loads the register defaults and clears sum, count, filter and level.

module battery_level_monitor_unit #(
	parameter int SAMPLES = blm_pkg::SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [blm_pkg::S_DATA_W-1:0]  s_tdata,   // [11:0] sense_mv
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] measured_pack_mv, [31:16] filtered_pack_mv,
	// [33:32] battery_level, [34] level_changed
	output logic [blm_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          cfg_we,
	input  logic [blm_pkg::IDX_W-1:0]     cfg_index,
	input  logic [blm_pkg::RES_W-1:0]     cfg_wdata
);

	localparam int SENSE_W = blm_pkg::SENSE_W;
	localparam int MV_W    = blm_pkg::MV_W;
	localparam int RES_W   = blm_pkg::RES_W;
	localparam int TOTAL_W = blm_pkg::TOTAL_W;
	localparam int NUM_W   = blm_pkg::NUM_W;
	localparam int SUM_W   = SENSE_W + $clog2(SAMPLES);
	localparam int CNT_W   = $clog2(SAMPLES + 1);
	localparam int FILT_W  = MV_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_MUL,
		ST_RND,
		ST_SCALE,
		ST_FILT,
		ST_CLASS
	} state_t;

	state_t              state_q;
	logic [RES_W-1:0]    div_top_q;
	logic [RES_W-1:0]    div_bot_q;
	logic [MV_W-1:0]     crit_ent_q;
	logic [MV_W-1:0]     crit_leave_q;
	logic [MV_W-1:0]     low_ent_q;
	logic [MV_W-1:0]     low_leave_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MV_W-1:0]     filt_q;
	blm_pkg::level_t     level_q;
	logic [MV_W-1:0]     meas_q;
	logic                out_valid_q;
	logic [blm_pkg::M_DATA_W-1:0] out_data_q;

	logic                s_acc;
	logic                last_smp;
	logic [SUM_W-1:0]    sum_nxt;
	logic                out_free;
	logic [MV_W-1:0]     meas_sat;
	logic [FILT_W-1:0]   filt_sum;
	logic [MV_W-1:0]     filt_nxt;
	blm_pkg::level_t     level_nxt;

	blm_pkg::div_req_t   div_req;
	blm_pkg::div_rsp_t   div_rsp;
	blm_pkg::mul_req_t   mul_req;
	blm_pkg::mul_rsp_t   mul_rsp;

	// Input request handshake and running sum
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign sum_nxt  = sum_q + SUM_W'(s_tdata[SENSE_W-1:0]);
	assign last_smp = (cnt_q == CNT_W'(SAMPLES - 1));
	assign out_free = !out_valid_q || m_tready;

	// Divider requests: average of the sum, then rounded divider scaling
	always_comb begin
		div_req = '0;
		if (s_acc && last_smp) begin
			div_req.start = 1'b1;
			div_req.numer = NUM_W'(sum_nxt);
			div_req.denom = RES_W'(SAMPLES);
		end else if (state_q == ST_RND) begin
			div_req.start = 1'b1;
			div_req.numer = NUM_W'(mul_rsp.prod) + NUM_W'(div_bot_q[RES_W-1:1]);
			div_req.denom = div_bot_q;
		end
	end

	// Multiplier request: average times divider total
	always_comb begin
		mul_req       = '0;
		mul_req.start = (state_q == ST_AVG) && div_rsp.done;
		mul_req.a     = div_rsp.quot[SENSE_W-1:0];
		mul_req.b     = TOTAL_W'(div_top_q) + TOTAL_W'(div_bot_q);
	end

	blm_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	blm_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Saturate the scaled value at full scale
	assign meas_sat = (div_rsp.quot[NUM_W-1:MV_W] != '0) ? '1 : div_rsp.quot[MV_W-1:0];

	// Low-pass filter; an unseeded filter takes the measurement
	assign filt_sum = FILT_W'({filt_q, 1'b0}) + FILT_W'(filt_q) + FILT_W'(meas_q);
	assign filt_nxt = (filt_q == '0) ? meas_q : filt_sum[FILT_W-1:2];

	// Level with separate enter and leave thresholds
	always_comb begin
		case (level_q)
			blm_pkg::LEVEL_CRIT: begin
				if (filt_q <= crit_leave_q)
					level_nxt = blm_pkg::LEVEL_CRIT;
				else if (filt_q <= low_ent_q)
					level_nxt = blm_pkg::LEVEL_LOW;
				else
					level_nxt = blm_pkg::LEVEL_OK;
			end
			blm_pkg::LEVEL_LOW: begin
				if (filt_q <= crit_ent_q)
					level_nxt = blm_pkg::LEVEL_CRIT;
				else if (filt_q < low_leave_q)
					level_nxt = blm_pkg::LEVEL_LOW;
				else
					level_nxt = blm_pkg::LEVEL_OK;
			end
			default: begin
				if (filt_q <= crit_ent_q)
					level_nxt = blm_pkg::LEVEL_CRIT;
				else if (filt_q <= low_ent_q)
					level_nxt = blm_pkg::LEVEL_LOW;
				else
					level_nxt = blm_pkg::LEVEL_OK;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_top_q    <= blm_pkg::DIV_TOP_RST;
			div_bot_q    <= blm_pkg::DIV_BOT_RST;
			crit_ent_q   <= blm_pkg::CRIT_ENT_RST;
			crit_leave_q <= blm_pkg::CRIT_LEAVE_RST;
			low_ent_q    <= blm_pkg::LOW_ENT_RST;
			low_leave_q  <= blm_pkg::LOW_LEAVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				blm_pkg::REG_DIV_TOP:    div_top_q    <= cfg_wdata;
				blm_pkg::REG_DIV_BOT:    div_bot_q    <= cfg_wdata;
				blm_pkg::REG_CRIT_ENT:   crit_ent_q   <= cfg_wdata[MV_W-1:0];
				blm_pkg::REG_CRIT_LEAVE: crit_leave_q <= cfg_wdata[MV_W-1:0];
				blm_pkg::REG_LOW_ENT:    low_ent_q    <= cfg_wdata[MV_W-1:0];
				blm_pkg::REG_LOW_LEAVE:  low_leave_q  <= cfg_wdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, monitor state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			filt_q      <= '0;
			level_q     <= blm_pkg::LEVEL_OK;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result when the register frees, else drop a taken one
			if (state_q == ST_CLASS && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (last_smp) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_AVG;
						end else begin
							sum_q <= sum_nxt;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_AVG: begin
					if (div_rsp.done)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_rsp.done)
						state_q <= ST_RND;
				end
				ST_RND: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (div_rsp.done)
						state_q <= ST_FILT;
				end
				ST_FILT: begin
					filt_q  <= filt_nxt;
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					if (out_free) begin
						level_q <= level_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath holding registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE && div_rsp.done)
			meas_q <= meas_sat;
		if (state_q == ST_CLASS && out_free)
			out_data_q <= {5'b0, (level_nxt != level_q), level_nxt, filt_q, meas_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Divider results only arrive while the sequencer waits for them
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_AVG || state_q == ST_SCALE))
		else $error("divider done outside a divide state");

	// Multiplier results only arrive while the sequencer waits for them
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_MUL))
		else $error("multiplier done outside the multiply state");

	// A pending result holds the sequencer in classification
	a_class_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLASS && out_valid_q && !m_tready) |=> (state_q == ST_CLASS))
		else $error("result overwritten before it was taken");

	// A shown result carries the current level
	a_level_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[33:32] == level_q))
		else $error("output level differs from monitor level");

	// The reading count stays inside one group
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SAMPLES))
		else $error("reading count out of range");

endmodule
